@@ sv/ptzfe_pkg.sv @@
// shared types and constants of the pan-tilt-zoom command frame encoder
`timescale 1ns / 1ps
package ptzfe_pkg;

  // opcodes
  localparam logic [3:0] OP_UP           = 4'd0;
  localparam logic [3:0] OP_DOWN         = 4'd1;
  localparam logic [3:0] OP_LEFT         = 4'd2;
  localparam logic [3:0] OP_RIGHT        = 4'd3;
  localparam logic [3:0] OP_ZOOM_IN      = 4'd4;
  localparam logic [3:0] OP_ZOOM_OUT     = 4'd5;
  localparam logic [3:0] OP_PRESET_SET   = 4'd6;
  localparam logic [3:0] OP_PRESET_GO    = 4'd7;
  localparam logic [3:0] OP_PRESET_CLEAR = 4'd8;

  // cmd2 codes
  localparam logic [7:0] CMD2_UP           = 8'h08;
  localparam logic [7:0] CMD2_DOWN         = 8'h10;
  localparam logic [7:0] CMD2_LEFT         = 8'h04;
  localparam logic [7:0] CMD2_RIGHT        = 8'h02;
  localparam logic [7:0] CMD2_ZOOM_A       = 8'h20;
  localparam logic [7:0] CMD2_ZOOM_B       = 8'h40;
  localparam logic [7:0] CMD2_PRESET_SET   = 8'h03;
  localparam logic [7:0] CMD2_PRESET_GO    = 8'h07;
  localparam logic [7:0] CMD2_PRESET_CLEAR = 8'h05;

  // frame framing bytes
  localparam logic [7:0] SYNC_D  = 8'hFF;
  localparam logic [7:0] SYNC_P  = 8'hA0;
  localparam logic [7:0] ETX_P   = 8'hAF;

  // protocol select values
  localparam logic PROTO_D = 1'b0;
  localparam logic PROTO_P = 1'b1;

  // configuration register indexes
  localparam int unsigned CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] CFG_PROTOCOL = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ADDRESS  = 2'd1;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [7:0] ADDRESS_RESET = 8'h01;

  // command queue depth, at least 2
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef struct packed {
    logic       protocol;
    logic [7:0] address;
  } cfg_t;

  // one classified command
  typedef struct packed {
    logic [7:0] cmd2;
    logic [7:0] data1;
    logic [7:0] data2;
    logic       with_stop;
  } cmd_t;

endpackage

@@ sv/ptzfe_front.sv @@
// front stage: accepts commands, decodes them into frame contents
`timescale 1ns / 1ps
module ptzfe_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ptzfe_pkg::cfg_t cfg_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [3:0]      opcode_i,
  input  logic [7:0]      move_speed_i,
  input  logic [7:0]      preset_number_i,
  output logic            cmd_valid_o,
  input  logic            cmd_ready_i,
  output ptzfe_pkg::cmd_t cmd_o
);

  logic            valid_q, valid_d;
  ptzfe_pkg::cmd_t cmd_q, cmd_d;
  logic            known;
  logic            take;

  always_comb begin
    cmd_d.cmd2      = 8'h00;
    cmd_d.data1     = 8'h00;
    cmd_d.data2     = 8'h00;
    cmd_d.with_stop = 1'b1;
    known           = 1'b1;
    case (opcode_i)
      ptzfe_pkg::OP_UP: begin
        cmd_d.cmd2  = ptzfe_pkg::CMD2_UP;
        cmd_d.data2 = move_speed_i;
      end
      ptzfe_pkg::OP_DOWN: begin
        cmd_d.cmd2  = ptzfe_pkg::CMD2_DOWN;
        cmd_d.data2 = move_speed_i;
      end
      ptzfe_pkg::OP_LEFT: begin
        cmd_d.cmd2  = ptzfe_pkg::CMD2_LEFT;
        cmd_d.data1 = move_speed_i;
      end
      ptzfe_pkg::OP_RIGHT: begin
        cmd_d.cmd2  = ptzfe_pkg::CMD2_RIGHT;
        cmd_d.data1 = move_speed_i;
      end
      // zoom codes swap between the two formats
      ptzfe_pkg::OP_ZOOM_IN: begin
        cmd_d.cmd2 = (cfg_i.protocol == ptzfe_pkg::PROTO_D) ?
                     ptzfe_pkg::CMD2_ZOOM_A : ptzfe_pkg::CMD2_ZOOM_B;
      end
      ptzfe_pkg::OP_ZOOM_OUT: begin
        cmd_d.cmd2 = (cfg_i.protocol == ptzfe_pkg::PROTO_D) ?
                     ptzfe_pkg::CMD2_ZOOM_B : ptzfe_pkg::CMD2_ZOOM_A;
      end
      ptzfe_pkg::OP_PRESET_SET: begin
        cmd_d.cmd2  = ptzfe_pkg::CMD2_PRESET_SET;
        cmd_d.data2 = preset_number_i;
      end
      ptzfe_pkg::OP_PRESET_GO: begin
        cmd_d.cmd2      = ptzfe_pkg::CMD2_PRESET_GO;
        cmd_d.data2     = preset_number_i;
        cmd_d.with_stop = 1'b0;
      end
      ptzfe_pkg::OP_PRESET_CLEAR: begin
        cmd_d.cmd2      = ptzfe_pkg::CMD2_PRESET_CLEAR;
        cmd_d.data2     = preset_number_i;
        cmd_d.with_stop = 1'b0;
      end
      default: begin
        known = 1'b0;
      end
    endcase
  end

  assign in_ready_o = !valid_q || cmd_ready_i;
  assign take       = in_valid_i && in_ready_o;

  // unknown opcodes are accepted and dropped here
  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = known;
    end else if (cmd_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      cmd_q <= cmd_d;
    end
  end

  assign cmd_valid_o = valid_q;
  assign cmd_o       = cmd_q;

endmodule

@@ sv/ptzfe_queue.sv @@
// small command queue between the decode front and the byte sequencer
`timescale 1ns / 1ps
module ptzfe_queue #(
  parameter int unsigned Depth = ptzfe_pkg::QUEUE_DEPTH
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  ptzfe_pkg::cmd_t push_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output ptzfe_pkg::cmd_t pop_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  ptzfe_pkg::cmd_t     slots_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     count_q, count_d;
  logic                push, pop;

  assign push_ready_o = (count_q != CntW'(Depth));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_o        = slots_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slots_q[wr_ptr_q] <= push_i;
    end
  end

endmodule

@@ sv/ptzfe_back.sv @@
// back stage: walks the bytes of the command frame and the stop frame
`timescale 1ns / 1ps
module ptzfe_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ptzfe_pkg::cfg_t cfg_i,
  input  logic            cmd_valid_i,
  output logic            cmd_ready_o,
  input  ptzfe_pkg::cmd_t cmd_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [7:0]      frame_byte_o,
  output logic            frame_end_o,
  output logic            last_o
);

  logic            busy_q, busy_d;
  logic            stop_q, stop_d;   // 1 while in the stop frame
  logic [2:0]      idx_q, idx_d;
  ptzfe_pkg::cmd_t cmd_q;
  logic            out_valid_q, out_valid_d;
  logic [7:0]      byte_q, byte_d;
  logic            end_q, end_d;
  logic            last_q, last_d;

  logic            adv;
  logic            take;
  logic [2:0]      last_idx;
  logic            at_end;
  logic            seq_done;
  logic [7:0]      cmd2, data1, data2;
  logic [7:0]      sum_chk, xor_chk;

  assign adv      = !out_valid_q || out_ready_i;
  assign last_idx = (cfg_i.protocol == ptzfe_pkg::PROTO_D) ? 3'd6 : 3'd7;
  assign at_end   = (idx_q == last_idx);
  assign seq_done = at_end && (stop_q || !cmd_q.with_stop);

  // the next command enters as the previous one issues its final byte
  assign cmd_ready_o = !busy_q || (adv && seq_done);
  assign take        = cmd_valid_i && cmd_ready_o;

  // stop frame carries zero command and data
  assign cmd2  = stop_q ? 8'h00 : cmd_q.cmd2;
  assign data1 = stop_q ? 8'h00 : cmd_q.data1;
  assign data2 = stop_q ? 8'h00 : cmd_q.data2;

  assign sum_chk = cfg_i.address + cmd2 + data1 + data2;
  assign xor_chk = ptzfe_pkg::SYNC_P ^ cfg_i.address ^ cmd2 ^ data1 ^ data2 ^
                   ptzfe_pkg::ETX_P;

  always_comb begin
    case (idx_q)
      3'd0: byte_d = (cfg_i.protocol == ptzfe_pkg::PROTO_D) ?
                     ptzfe_pkg::SYNC_D : ptzfe_pkg::SYNC_P;
      3'd1: byte_d = cfg_i.address;
      3'd2: byte_d = 8'h00;
      3'd3: byte_d = cmd2;
      3'd4: byte_d = data1;
      3'd5: byte_d = data2;
      3'd6: byte_d = (cfg_i.protocol == ptzfe_pkg::PROTO_D) ? sum_chk : ptzfe_pkg::ETX_P;
      3'd7: byte_d = xor_chk;
      default: byte_d = 8'h00;
    endcase
  end

  assign end_d  = at_end;
  assign last_d = seq_done;

  always_comb begin
    busy_d      = busy_q;
    stop_d      = stop_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    if (adv) begin
      out_valid_d = busy_q;
      if (busy_q) begin
        if (!at_end) begin
          idx_d = idx_q + 1'b1;
        end else if (!seq_done) begin
          stop_d = 1'b1;
          idx_d  = '0;
        end else begin
          busy_d = 1'b0;
        end
      end
    end
    if (take) begin
      busy_d = 1'b1;
      stop_d = 1'b0;
      idx_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      stop_q      <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      stop_q      <= stop_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      cmd_q <= cmd_i;
    end
    if (adv && busy_q) begin
      byte_q <= byte_d;
      end_q  <= end_d;
      last_q <= last_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign frame_byte_o = byte_q;
  assign frame_end_o  = end_q;
  assign last_o       = last_q;

endmodule

@@ sv/ptz_command_frame_encoder.sv @@
// top level of the pan-tilt-zoom command frame encoder
//
//  channel  | signals                                        | direction
//  ---------+------------------------------------------------+----------
//  command  | in_valid_i/in_ready_o, opcode, speed, preset   | in
//  bytes    | out_valid_o/out_ready_i, byte, frame_end, last | out
//  config   | cfg_we_i, cfg_index_i, cfg_wdata_i             | in
//
// one result byte per cycle while out_ready_i is high: a command gives one frame
// of 7 or 8 bytes, two with the stop frame, set by the byte sequencer in the back stage.
// a command is decoded into a register and queued, so the front keeps taking
// commands while the sequencer or output stalls, until full. unknown opcodes are
// taken and produce nothing. reset leaves Pelco-D with address 1.
`timescale 1ns / 1ps
module ptz_command_frame_encoder #(
  parameter int unsigned QueueDepth = ptzfe_pkg::QUEUE_DEPTH
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [ptzfe_pkg::CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [ptzfe_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [3:0]                       opcode_i,
  input  logic [7:0]                       move_speed_i,
  input  logic [7:0]                       preset_number_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [7:0]                       frame_byte_o,
  output logic                             frame_end_o,
  output logic                             last_o
);

  ptzfe_pkg::cfg_t cfg_q;
  ptzfe_pkg::cmd_t front_cmd, queue_cmd;
  logic            front_valid, front_ready;
  logic            queue_valid, queue_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.protocol <= ptzfe_pkg::PROTO_D;
      cfg_q.address  <= ptzfe_pkg::ADDRESS_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        ptzfe_pkg::CFG_PROTOCOL: cfg_q.protocol <= cfg_wdata_i[0];
        ptzfe_pkg::CFG_ADDRESS:  cfg_q.address  <= cfg_wdata_i[7:0];
        default: begin
        end
      endcase
    end
  end

  ptzfe_front u_front (
    .clk_i,
    .rst_ni,
    .cfg_i          (cfg_q),
    .in_valid_i,
    .in_ready_o,
    .opcode_i,
    .move_speed_i,
    .preset_number_i,
    .cmd_valid_o    (front_valid),
    .cmd_ready_i    (front_ready),
    .cmd_o          (front_cmd)
  );

  ptzfe_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i,
    .rst_ni,
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .push_i       (front_cmd),
    .pop_valid_o  (queue_valid),
    .pop_ready_i  (queue_ready),
    .pop_o        (queue_cmd)
  );

  ptzfe_back u_back (
    .clk_i,
    .rst_ni,
    .cfg_i        (cfg_q),
    .cmd_valid_i  (queue_valid),
    .cmd_ready_o  (queue_ready),
    .cmd_i        (queue_cmd),
    .out_valid_o,
    .out_ready_i,
    .frame_byte_o,
    .frame_end_o,
    .last_o
  );

endmodule

@@ tb/sv/ptz_command_frame_encoder_test.sv @@
// self-checking testbench of the pan-tilt-zoom command frame encoder
`timescale 1ns / 1ps
module ptz_command_frame_encoder_test;

  localparam logic [3:0] OP_FIRST_UNKNOWN = 4'd9;
  localparam logic [3:0] OP_MID_UNKNOWN   = 4'd12;
  localparam logic [3:0] OP_LAST_UNKNOWN  = 4'd15;
  localparam logic [ptzfe_pkg::CFG_INDEX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [ptzfe_pkg::CFG_INDEX_W-1:0] CFG_SPARE_HI = 2'd3;

  localparam int RANDOM_PHASES   = 6;
  localparam int PHASE_ITEMS     = 57;
  localparam int SETTLE_CYCLES   = 24;
  localparam int LONG_STALL      = 300;
  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int MAX_PRINTS      = 100;

  typedef struct packed {
    logic [3:0] opcode;
    logic [7:0] speed;
    logic [7:0] preset;
  } ptz_cmd_t;

  typedef struct packed {
    logic [7:0] value;
    logic       frame_end;
    logic       last_of_cmd;
  } frame_byte_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [ptzfe_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [ptzfe_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  ptz_cmd_t offered = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [7:0] frame_byte;
  logic frame_end;
  logic last;

  // encoder settings as the predictor sees them
  logic proto_sel = ptzfe_pkg::PROTO_D;
  logic [7:0] cam_addr = ptzfe_pkg::ADDRESS_RESET;

  ptz_cmd_t cmds_pending[$];
  frame_byte_t frames_due[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatches = 0;
  int quiet_cycles = 0;
  int stall_left = 0;
  logic long_stall_req = 1'b0;
  logic long_stall_ack = 1'b0;

  ptz_command_frame_encoder DUT (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .opcode_i       (offered.opcode),
    .move_speed_i   (offered.speed),
    .preset_number_i(offered.preset),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .frame_byte_o   (frame_byte),
    .frame_end_o    (frame_end),
    .last_o         (last)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    if (mismatches < MAX_PRINTS) begin
      $display("mismatch at %0t: %s", $realtime, msg);
    end
    mismatches++;
  endtask

  function automatic void push_frame(input logic [7:0] cmd2, input logic [7:0] d1,
                                     input logic [7:0] d2, input logic final_frame);
    logic [7:0] b [8];
    int n;
    b[1] = cam_addr;
    b[2] = 8'h00;
    b[3] = cmd2;
    b[4] = d1;
    b[5] = d2;
    if (proto_sel == ptzfe_pkg::PROTO_D) begin
      b[0] = ptzfe_pkg::SYNC_D;
      b[6] = b[1] + b[2] + b[3] + b[4] + b[5];
      n = 7;
    end else begin
      b[0] = ptzfe_pkg::SYNC_P;
      b[6] = ptzfe_pkg::ETX_P;
      b[7] = b[0] ^ b[1] ^ b[2] ^ b[3] ^ b[4] ^ b[5] ^ b[6];
      n = 8;
    end
    for (int i = 0; i < n; i++) begin
      frames_due.push_back('{b[i], i == n - 1, (i == n - 1) && final_frame});
    end
  endfunction

  // expected bytes of one command, with the stop frame where one follows
  function automatic void encode_command(input ptz_cmd_t c);
    logic [7:0] cmd2;
    logic [7:0] d1;
    logic [7:0] d2;
    logic with_stop;
    d1 = 8'h00;
    d2 = 8'h00;
    with_stop = 1'b1;
    case (c.opcode)
      ptzfe_pkg::OP_UP: begin
        cmd2 = ptzfe_pkg::CMD2_UP;
        d2 = c.speed;
      end
      ptzfe_pkg::OP_DOWN: begin
        cmd2 = ptzfe_pkg::CMD2_DOWN;
        d2 = c.speed;
      end
      ptzfe_pkg::OP_LEFT: begin
        cmd2 = ptzfe_pkg::CMD2_LEFT;
        d1 = c.speed;
      end
      ptzfe_pkg::OP_RIGHT: begin
        cmd2 = ptzfe_pkg::CMD2_RIGHT;
        d1 = c.speed;
      end
      // zoom codes swap between the two protocols
      ptzfe_pkg::OP_ZOOM_IN: begin
        cmd2 = (proto_sel == ptzfe_pkg::PROTO_D) ? ptzfe_pkg::CMD2_ZOOM_A :
                                                   ptzfe_pkg::CMD2_ZOOM_B;
      end
      ptzfe_pkg::OP_ZOOM_OUT: begin
        cmd2 = (proto_sel == ptzfe_pkg::PROTO_D) ? ptzfe_pkg::CMD2_ZOOM_B :
                                                   ptzfe_pkg::CMD2_ZOOM_A;
      end
      ptzfe_pkg::OP_PRESET_SET: begin
        cmd2 = ptzfe_pkg::CMD2_PRESET_SET;
        d2 = c.preset;
      end
      ptzfe_pkg::OP_PRESET_GO: begin
        cmd2 = ptzfe_pkg::CMD2_PRESET_GO;
        d2 = c.preset;
        with_stop = 1'b0;
      end
      ptzfe_pkg::OP_PRESET_CLEAR: begin
        cmd2 = ptzfe_pkg::CMD2_PRESET_CLEAR;
        d2 = c.preset;
        with_stop = 1'b0;
      end
      default: begin
        return;
      end
    endcase
    push_frame(cmd2, d1, d2, !with_stop);
    if (with_stop) begin
      push_frame(8'h00, 8'h00, 8'h00, 1'b1);
    end
  endfunction

  task automatic queue_cmd(input logic [3:0] op, input logic [7:0] spd,
                           input logic [7:0] pre);
    ptz_cmd_t c;
    c.opcode = op;
    c.speed = spd;
    c.preset = pre;
    cmds_pending.push_back(c);
  endtask

  function automatic logic [7:0] rand_operand();
    int pick;
    pick = $urandom_range(9);
    if (pick == 0) begin
      return 8'h00;
    end else if (pick == 1) begin
      return 8'hFF;
    end
    return 8'($urandom);
  endfunction

  task automatic write_reg(input logic [ptzfe_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [7:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == ptzfe_pkg::CFG_PROTOCOL) begin
      proto_sel = val[0];
    end else if (idx == ptzfe_pkg::CFG_ADDRESS) begin
      cam_addr = val;
    end
  endtask

  // unknown opcodes leave nothing to wait for, so keep settling after the queues drain
  task automatic wait_idle();
    while (cmds_pending.size() != 0 || in_valid || frames_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // command driver
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        encode_command(offered);
      end
      if (!in_valid || in_ready) begin
        if (cmds_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          offered <= cmds_pending.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // byte monitor and receiver stalls
  always @(posedge clk or negedge rst_n) begin : receiver
    frame_byte_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (frames_due.size() == 0) begin
          report_mismatch($sformatf("unexpected byte %h", frame_byte));
        end else begin
          want = frames_due.pop_front();
          if (frame_byte !== want.value) begin
            report_mismatch($sformatf("frame_byte %h, expected %h", frame_byte, want.value));
          end
          if (frame_end !== want.frame_end) begin
            report_mismatch($sformatf("frame_end %b, expected %b", frame_end,
                                      want.frame_end));
          end
          if (last !== want.last_of_cmd) begin
            report_mismatch($sformatf("last %b, expected %b", last, want.last_of_cmd));
          end
        end
      end
      if (stall_left > 0) begin
        stall_left = stall_left - 1;
        out_ready <= 1'b0;
      end else if (long_stall_req != long_stall_ack) begin
        long_stall_ack = long_stall_req;
        stall_left = LONG_STALL;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("** ptz_command_frame_encoder: FAILED **");
      $finish;
    end
  end

  initial begin
    logic proto;
    logic [7:0] addr;
    logic [3:0] op;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: Pelco-D, address 1
    queue_cmd(ptzfe_pkg::OP_UP, 8'hFF, 8'h00);
    queue_cmd(ptzfe_pkg::OP_UP, 8'h00, 8'hFF);
    queue_cmd(ptzfe_pkg::OP_DOWN, 8'h80, 8'h33);
    queue_cmd(ptzfe_pkg::OP_LEFT, 8'hFF, 8'hFF);
    queue_cmd(ptzfe_pkg::OP_RIGHT, 8'h01, 8'h00);
    queue_cmd(ptzfe_pkg::OP_ZOOM_IN, 8'hFF, 8'hFF);
    queue_cmd(ptzfe_pkg::OP_ZOOM_OUT, 8'h00, 8'h00);
    queue_cmd(ptzfe_pkg::OP_PRESET_SET, 8'hFF, 8'hFF);
    queue_cmd(ptzfe_pkg::OP_PRESET_GO, 8'h00, 8'h00);
    queue_cmd(ptzfe_pkg::OP_PRESET_CLEAR, 8'hAA, 8'h80);
    queue_cmd(OP_FIRST_UNKNOWN, 8'h55, 8'h55);
    queue_cmd(OP_LAST_UNKNOWN, 8'hFF, 8'hFF);
    wait_idle();

    // upper bits of the protocol write are dropped; spare indexes do nothing
    write_reg(ptzfe_pkg::CFG_PROTOCOL, 8'hFF);
    write_reg(ptzfe_pkg::CFG_ADDRESS, 8'hFF);
    write_reg(CFG_SPARE_LO, 8'h00);
    write_reg(CFG_SPARE_HI, 8'h00);
    queue_cmd(ptzfe_pkg::OP_DOWN, 8'hFF, 8'h00);
    queue_cmd(ptzfe_pkg::OP_LEFT, 8'h00, 8'hFF);
    queue_cmd(ptzfe_pkg::OP_RIGHT, 8'hFF, 8'h00);
    queue_cmd(ptzfe_pkg::OP_ZOOM_IN, 8'h00, 8'h00);
    queue_cmd(ptzfe_pkg::OP_ZOOM_OUT, 8'hFF, 8'hFF);
    queue_cmd(ptzfe_pkg::OP_PRESET_SET, 8'h00, 8'h00);
    queue_cmd(ptzfe_pkg::OP_PRESET_GO, 8'hFF, 8'hFF);
    queue_cmd(ptzfe_pkg::OP_PRESET_CLEAR, 8'h00, 8'hFF);
    queue_cmd(ptzfe_pkg::OP_UP, 8'h55, 8'hAA);
    queue_cmd(OP_MID_UNKNOWN, 8'h00, 8'h00);

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      wait_idle();
      send_idle_pct = (ph < 2) ? 35 : (ph < 4) ? 68 : 0;
      recv_idle_pct = (ph < 2) ? 68 : (ph < 4) ? 35 : 0;
      proto = (ph % 2 == 0) ? ptzfe_pkg::PROTO_P : ptzfe_pkg::PROTO_D;
      addr = (ph == 1) ? 8'h00 : (ph == 2) ? 8'hFF : 8'($urandom);
      write_reg(ptzfe_pkg::CFG_PROTOCOL, {7'($urandom), proto});
      write_reg(ptzfe_pkg::CFG_ADDRESS, addr);
      if (ph == 3) begin
        write_reg(CFG_SPARE_HI, 8'($urandom));
      end
      // output blocked while the driver keeps offering commands
      if (ph == 4) begin
        long_stall_req = ~long_stall_req;
      end
      repeat (PHASE_ITEMS) begin
        if ($urandom_range(9) == 0) begin
          op = 4'($urandom_range(OP_LAST_UNKNOWN, OP_FIRST_UNKNOWN));
        end else begin
          op = 4'($urandom_range(ptzfe_pkg::OP_PRESET_CLEAR, ptzfe_pkg::OP_UP));
        end
        queue_cmd(op, rand_operand(), rand_operand());
      end
    end
    wait_idle();

    if (mismatches == 0) begin
      $display("** ptz_command_frame_encoder: PASSED **");
    end else begin
      $display("** ptz_command_frame_encoder: FAILED **");
    end
    $finish;
  end

endmodule
